// ===== rtl/text_console_cursor_engine_macros.svh =====
// Assertion helpers shared by the console modules.
// The asserting module must have clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define TCCE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcce_pkg.sv =====
package tcce_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = ROWS * COLUMNS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] PRINT_MAX  = 8'h7F;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] ATTR_RESET = 8'h0F;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        logic accept;
        logic sweep_en;
        logic scroll_commit;
    } tcce_cmd_t;

    typedef struct packed {
        logic op_clear;
        logic op_scroll;
        logic sweep_last;
    } tcce_status_t;

endpackage

// ===== rtl/tcce_ctrl.sv =====
`include "text_console_cursor_engine_macros.svh"

module tcce_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tcce_pkg::tcce_status_t status,
    output tcce_pkg::tcce_cmd_t   cmd,
    output logic                  busy,
    output logic                  done
);
    import tcce_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCROLL = 4'b0010,
        S_CLEAR  = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    assign cmd.accept        = start && !busy;
    assign cmd.sweep_en      = (state_reg == S_SCROLL) || (state_reg == S_CLEAR);
    assign cmd.scroll_commit = (state_reg == S_SCROLL) && status.sweep_last;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (status.op_clear)
                        state_next = S_CLEAR;
                    else if (status.op_scroll)
                        state_next = S_SCROLL;
                    else
                        state_next = S_DONE;
                end
            end
            S_SCROLL, S_CLEAR:
            begin
                if (status.sweep_last)
                    state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `TCCE_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `TCCE_ASSERT_NEXT(a_accept_busy, cmd.accept, busy, "accepted request did not raise busy")
    `TCCE_ASSERT_NEXT(a_scroll_end, cmd.scroll_commit, done, "scroll end not followed by result")

endmodule

// ===== rtl/tcce_datapath.sv =====
`include "text_console_cursor_engine_macros.svh"

module tcce_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcce_pkg::tcce_cmd_t    cmd,
    output tcce_pkg::tcce_status_t status,
    input  logic [1:0]             operation,
    input  logic [7:0]             char_code,
    input  logic [4:0]             read_row,
    input  logic [6:0]             read_col,
    input  logic                   cfg_valid,
    input  logic [7:0]             cfg_data,
    output logic [15:0]            cell_value,
    output logic [6:0]             cursor_col,
    output logic [4:0]             cursor_row,
    output logic [10:0]            cursor_offset
);
    import tcce_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;
    logic              read_ok_reg;

    logic [7:0]        attr_reg;
    logic [COL_W-1:0]  cursor_x_reg;
    logic [ROW_W-1:0]  cursor_y_reg;
    logic [ROW_W-1:0]  top_reg;
    logic [ADDR_W-1:0] sweep_addr_reg;
    logic [ADDR_W-1:0] sweep_end_reg;

    logic [COL_W:0]    x_wide;
    logic [ROW_W:0]    y_wide;
    logic [COL_W-1:0]  cursor_x_next;
    logic [ROW_W-1:0]  cursor_y_next;
    logic              scroll;
    logic              put_we;
    logic [7:0]        put_char;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W:0]    put_phys_sum;
    logic [ROW_W-1:0]  put_phys;
    logic [ADDR_W-1:0] put_addr;
    logic [ROW_W:0]    rd_phys_sum;
    logic [ROW_W-1:0]  rd_phys;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_ok;
    logic [ADDR_W-1:0] row_base;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [CELL_W-1:0] blank;
    logic              is_put;

    assign is_put = (operation == OP_PUT);
    assign blank  = {attr_reg, BLANK_CHAR};

    // Cursor motion for one byte, then wrap and scroll checks.
    always_comb
    begin
        x_wide   = {1'b0, cursor_x_reg};
        y_wide   = {1'b0, cursor_y_reg};
        put_we   = 1'b0;
        put_char = char_code;
        put_col  = cursor_x_reg;
        if (char_code == CH_BS)
        begin
            if (cursor_x_reg != '0)
            begin
                x_wide   = x_wide - 1'b1;
                put_col  = cursor_x_reg - 1'b1;
                put_char = BLANK_CHAR;
                put_we   = 1'b1;
            end
        end
        else if (char_code == CH_TAB)
        begin
            x_wide = {1'b0, cursor_x_reg - COL_W'(cursor_x_reg % TAB_STOP)}
                     + (COL_W+1)'(TAB_STOP);
        end
        else if (char_code == CH_CR)
        begin
            x_wide = '0;
        end
        else if (char_code == CH_LF)
        begin
            x_wide = '0;
            y_wide = y_wide + 1'b1;
        end
        else if (char_code >= BLANK_CHAR && char_code <= PRINT_MAX)
        begin
            x_wide = x_wide + 1'b1;
            put_we = 1'b1;
        end

        if (x_wide >= (COL_W+1)'(COLUMNS))
        begin
            x_wide = '0;
            y_wide = y_wide + 1'b1;
        end

        scroll = (y_wide >= (ROW_W+1)'(ROWS));
        if (scroll)
            y_wide = (ROW_W+1)'(ROWS - 1);

        cursor_x_next = x_wide[COL_W-1:0];
        cursor_y_next = y_wide[ROW_W-1:0];
    end

    // Logical row to physical row over the circular row store.
    always_comb
    begin
        put_phys_sum = {1'b0, top_reg} + {1'b0, cursor_y_reg};
        if (put_phys_sum >= (ROW_W+1)'(ROWS))
            put_phys_sum = put_phys_sum - (ROW_W+1)'(ROWS);
        put_phys = put_phys_sum[ROW_W-1:0];
        put_addr = ADDR_W'(put_phys * COLUMNS) + ADDR_W'(put_col);

        rd_phys_sum = {1'b0, top_reg} + {1'b0, read_row};
        if (rd_phys_sum >= (ROW_W+1)'(ROWS))
            rd_phys_sum = rd_phys_sum - (ROW_W+1)'(ROWS);
        rd_phys = rd_phys_sum[ROW_W-1:0];
        rd_addr = ADDR_W'(rd_phys * COLUMNS) + ADDR_W'(read_col);
        rd_ok   = (read_row < ROW_W'(ROWS)) && (read_col < COL_W'(COLUMNS));
    end

    assign row_base = ADDR_W'(top_reg * COLUMNS);

    always_comb
    begin
        if (cmd.sweep_en)
        begin
            we    = 1'b1;
            waddr = sweep_addr_reg;
            wdata = blank;
        end
        else
        begin
            we    = cmd.accept && is_put && put_we;
            waddr = put_addr;
            wdata = {attr_reg, put_char};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            read_ok_reg <= (operation == OP_READ) && rd_ok;
            if (operation == OP_CLEAR)
            begin
                sweep_addr_reg <= '0;
                sweep_end_reg  <= ADDR_W'(CELLS - 1);
            end
            else
            begin
                sweep_addr_reg <= row_base;
                sweep_end_reg  <= row_base + ADDR_W'(COLUMNS - 1);
            end
        end
        else if (cmd.sweep_en)
        begin
            sweep_addr_reg <= sweep_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg     <= ATTR_RESET;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            top_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
                attr_reg <= cfg_data;
            if (cmd.accept && operation == OP_CLEAR)
            begin
                cursor_x_reg <= '0;
                cursor_y_reg <= '0;
                top_reg      <= '0;
            end
            else if (cmd.accept && is_put)
            begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
            end
            // advance the top row once the old top row is blanked
            if (cmd.scroll_commit)
            begin
                if (top_reg == ROW_W'(ROWS - 1))
                    top_reg <= '0;
                else
                    top_reg <= top_reg + 1'b1;
            end
        end
    end

    assign status.op_clear   = (operation == OP_CLEAR);
    assign status.op_scroll  = is_put && scroll;
    assign status.sweep_last = (sweep_addr_reg == sweep_end_reg);

    assign cell_value    = read_ok_reg ? rdata_reg : '0;
    assign cursor_col    = cursor_x_reg;
    assign cursor_row    = cursor_y_reg;
    assign cursor_offset = ADDR_W'(cursor_y_reg * COLUMNS) + ADDR_W'(cursor_x_reg);

    `TCCE_ASSERT_ALWAYS(a_col_range, cursor_x_reg < COL_W'(COLUMNS), "cursor column out of range")
    `TCCE_ASSERT_ALWAYS(a_row_range, cursor_y_reg < ROW_W'(ROWS), "cursor row out of range")
    `TCCE_ASSERT_ALWAYS(a_top_range, top_reg < ROW_W'(ROWS), "top row base out of range")

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// Character-cell text console, 25 rows by 80 columns of 16-bit cells.
// Request channel: drive operation, char_code, read_row and read_col with
// start high; the request is taken at the clock edge where busy is low.
// Put character and read cell finish in the cycle after the request: done is
// high for exactly one cycle with cell_value and the cursor fields. The
// receiver cannot stall; sample the result while done is high.
// A request is taken only after the last one is done. A put that scrolls
// blanks the old top row through the single memory write port before done.
// Clear sweeps all 2000 cells before done.
// Attribute channel: cfg_valid with cfg_data writes the colour byte; cfg_ready
// is high only while busy and start are both low, so no request sees it change.
// Reset clears the cursor, the top-row base and the state machine and sets
// the attribute to 0x0F. Screen cells are undefined until a clear, so
// issue a clear before the first read.
module text_console_cursor_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  char_code,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        done,
    output logic [15:0] cell_value,
    output logic [6:0]  cursor_col,
    output logic [4:0]  cursor_row,
    output logic [10:0] cursor_offset
);
    import tcce_pkg::*;

    tcce_cmd_t    cmd;
    tcce_status_t status;

    // hold attribute writes off while a request is taken or in flight
    assign cfg_ready = !busy && !start;

    tcce_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tcce_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .char_code     (char_code),
        .read_row      (read_row),
        .read_col      (read_col),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .cell_value    (cell_value),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .cursor_offset (cursor_offset)
    );

endmodule

// ===== verif/console_cursor_checker.sv =====
module console_cursor_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  char_code,
    input  logic [4:0]  read_row,
    input  logic [6:0]  read_col,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        done,
    input  logic [15:0] cell_value,
    input  logic [6:0]  cursor_col,
    input  logic [4:0]  cursor_row,
    input  logic [10:0] cursor_offset,
    output int          pending,
    output int          mismatches,
    output int          scrolls
);
    import tcce_pkg::*;

    typedef struct packed {
        logic [15:0] cell_word;
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] offset;
    } cursor_report_t;

    cursor_report_t awaited_reports[$];

    // Screen image kept as a circular row store, like the block does it.
    logic [15:0] screen_mirror [CELLS];
    int unsigned base_row;
    int unsigned cur_x;
    int unsigned cur_y;
    logic [7:0]  attr_shadow;
    int          error_total;
    int          scroll_total;

    assign mismatches = error_total;
    assign scrolls    = scroll_total;

    function automatic int unsigned cell_slot(int unsigned row, int unsigned col);
        return ((base_row + row) % ROWS) * COLUMNS + col;
    endfunction

    function automatic void blank_row(int unsigned phys);
        for (int c = 0; c < COLUMNS; c++)
            screen_mirror[phys * COLUMNS + c] = {attr_shadow, BLANK_CHAR};
    endfunction

    function automatic cursor_report_t advance_console(logic [1:0] op, logic [7:0] ch,
                                                       logic [4:0] rr, logic [6:0] rc);
        cursor_report_t rep;
        rep.cell_word = '0;
        if (op == OP_PUT)
        begin
            if (ch == CH_BS)
            begin
                if (cur_x != 0)
                begin
                    cur_x--;
                    screen_mirror[cell_slot(cur_y, cur_x)] = {attr_shadow, BLANK_CHAR};
                end
            end
            else if (ch == CH_TAB)
                cur_x = cur_x - cur_x % TAB_STOP + TAB_STOP;
            else if (ch == CH_CR)
                cur_x = 0;
            else if (ch == CH_LF)
            begin
                cur_x = 0;
                cur_y++;
            end
            else if (ch >= BLANK_CHAR && ch <= PRINT_MAX)
            begin
                screen_mirror[cell_slot(cur_y, cur_x)] = {attr_shadow, ch};
                cur_x++;
            end
            // wrap and scroll apply to every byte, ignored ones too
            if (cur_x >= COLUMNS)
            begin
                cur_x = 0;
                cur_y++;
            end
            if (cur_y >= ROWS)
            begin
                blank_row(base_row);
                base_row = (base_row + 1) % ROWS;
                cur_y = ROWS - 1;
                scroll_total++;
            end
        end
        else if (op == OP_CLEAR)
        begin
            for (int r = 0; r < ROWS; r++)
                blank_row(r);
            base_row = 0;
            cur_x = 0;
            cur_y = 0;
        end
        else if (op == OP_READ && rr < ROWS && rc < COLUMNS)
            rep.cell_word = screen_mirror[cell_slot(rr, rc)];
        rep.col    = 7'(cur_x);
        rep.row    = 5'(cur_y);
        rep.offset = 11'(cur_y * COLUMNS + cur_x);
        return rep;
    endfunction

    function automatic void check_field(string label, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, label, want, want, got, got);
            error_total++;
        end
    endfunction

    always @(posedge clk)
    begin
        cursor_report_t want;
        if (!rst_n)
        begin
            awaited_reports.delete();
            base_row     = 0;
            cur_x        = 0;
            cur_y        = 0;
            attr_shadow  = ATTR_RESET;
            error_total  = 0;
            scroll_total = 0;
            pending     <= 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $display("%0t: result with no request waiting: expected none, actual cell 0x%0h col %0d row %0d offset %0d",
                             $time, cell_value, cursor_col, cursor_row, cursor_offset);
                    error_total++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("cell_value", want.cell_word, cell_value);
                    check_field("cursor_col", want.col, cursor_col);
                    check_field("cursor_row", want.row, cursor_row);
                    check_field("cursor_offset", want.offset, cursor_offset);
                end
            end
            if (cfg_valid && cfg_ready)
                attr_shadow = cfg_data;
            if (start && !busy)
                awaited_reports.push_back(advance_console(operation, char_code,
                                                          read_row, read_col));
            pending <= awaited_reports.size();
        end
    end

endmodule

// ===== verif/text_console_cursor_engine_tb.sv =====
module text_console_cursor_engine_tb;
    import tcce_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HALF_PERIOD  = 6;
    localparam int MAX_CLEARS   = 40;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 290;
    localparam int TAIL_CYCLES  = 2100;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [1:0]  operation = '0;
    logic [7:0]  char_code = '0;
    logic [4:0]  read_row  = '0;
    logic [6:0]  read_col  = '0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = '0;
    logic        busy;
    logic        cfg_ready;
    logic        done;
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;

    int pending;
    int mismatches;
    int scrolls;
    int request_count = 0;
    int put_count     = 0;
    int clear_count   = 0;
    int read_count    = 0;
    int attr_writes   = 0;

    always #HALF_PERIOD clk = ~clk;

    text_console_cursor_engine dut (.*);

    console_cursor_checker watch (.*);

    task automatic issue(input logic [1:0] op, input logic [7:0] ch,
                         input logic [4:0] rr, input logic [6:0] rc, input bit gappy);
        int gap;
        operation <= op;
        char_code <= ch;
        read_row  <= rr;
        read_col  <= rc;
        start     <= 1'b1;
        do @(posedge clk); while (busy);
        request_count++;
        if (op == OP_PUT)
            put_count++;
        else if (op == OP_CLEAR)
            clear_count++;
        else if (op == OP_READ)
            read_count++;
        gap = 0;
        if (gappy && $urandom_range(0, 3) != 0)
            gap = $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        attr_writes++;
    endtask

    task automatic random_request(input bit lf_heavy, input bit allow_clear, input bit gappy);
        int pick;
        logic [7:0] ch;
        logic [4:0] rr;
        logic [6:0] rc;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom);
        rr   = 5'($urandom);
        rc   = 7'($urandom);
        if (allow_clear && clear_count < MAX_CLEARS && pick < 2)
            issue(OP_CLEAR, ch, rr, rc, gappy);
        else if (pick < (lf_heavy ? 45 : 14))
        begin
            if (lf_heavy && $urandom_range(0, 3) != 0)
                ch = CH_LF;
            else
                case ($urandom_range(0, 3))
                    0:       ch = CH_BS;
                    1:       ch = CH_TAB;
                    2:       ch = CH_CR;
                    default: ch = CH_LF;
                endcase
            issue(OP_PUT, ch, rr, rc, gappy);
        end
        else if (pick < 62)
            issue(OP_PUT, 8'($urandom_range(BLANK_CHAR, PRINT_MAX)), rr, rc, gappy);
        else if (pick < 68)
            issue(OP_PUT, ch, rr, rc, gappy);
        else if (pick < 70)
            issue(OP_UNUSED, ch, rr, rc, gappy);
        else
        begin
            // mostly on-screen cells, now and then anything the fields allow
            if ($urandom_range(0, 6) != 0)
            begin
                rr = 5'($urandom_range(0, ROWS - 1));
                rc = 7'($urandom_range(0, COLUMNS - 1));
            end
            issue(OP_READ, ch, rr, rc, gappy);
        end
    endtask

    initial
    begin
        logic [7:0] attr;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Cursor moves and ignored bytes on a screen not yet cleared.
        issue(OP_PUT, 8'h41, 5'd0, 7'd0, 1'b1);
        issue(OP_PUT, BLANK_CHAR, 5'd0, 7'd0, 1'b1);
        issue(OP_PUT, PRINT_MAX, 5'd0, 7'd0, 1'b1);
        issue(OP_PUT, CH_BS, 5'd0, 7'd0, 1'b1);
        issue(OP_PUT, CH_TAB, 5'd0, 7'd0, 1'b1);
        issue(OP_PUT, CH_CR, 5'd0, 7'd0, 1'b1);
        issue(OP_PUT, CH_BS, 5'd0, 7'd0, 1'b1);
        issue(OP_PUT, 8'h00, 5'd31, 7'd127, 1'b1);
        issue(OP_PUT, 8'h1F, 5'd0, 7'd0, 1'b1);
        issue(OP_PUT, 8'h80, 5'd0, 7'd0, 1'b1);
        issue(OP_PUT, 8'hFF, 5'd0, 7'd0, 1'b1);
        issue(OP_UNUSED, 8'hFF, 5'd31, 7'd127, 1'b1);

        // Reads only once the screen has been cleared.
        issue(OP_CLEAR, 8'h00, 5'd0, 7'd0, 1'b1);
        issue(OP_PUT, 8'h48, 5'd0, 7'd0, 1'b1);
        issue(OP_READ, 8'h00, 5'd0, 7'd0, 1'b1);
        issue(OP_READ, 8'h00, 5'(ROWS - 1), 7'(COLUMNS - 1), 1'b1);
        issue(OP_READ, 8'hFF, 5'd31, 7'd127, 1'b1);
        issue(OP_READ, 8'h00, 5'(ROWS), 7'd0, 1'b1);
        issue(OP_READ, 8'h00, 5'd0, 7'(COLUMNS), 1'b1);
        // tab past the last column wraps to the next row
        repeat (10) issue(OP_PUT, CH_TAB, 5'd0, 7'd0, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       attr = 8'h00;
                1:       attr = 8'hFF;
                3:       attr = 8'h80;
                5:       attr = 8'h01;
                default: attr = 8'($urandom);
            endcase
            settle();
            write_attribute(attr);
            // phase 2 scrolls hard with no clears so the row base wraps around
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) == 0)
                    settle();
                random_request(p == 2, p != 2, p % 2 == 0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d puts, %0d clears, %0d reads, %0d scrolls,",
                 request_count, put_count, clear_count, read_count, scrolls);
        $display("under %0d attribute settings plus the reset colour.", attr_writes);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
